/* sv/r0s_pkg.sv */
// ----------------------------------------------------------------------------
// r0s_pkg
// Shared types and constants for the RAID0 request splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package r0s_pkg;

    localparam int OFF_W     = 48;   // array / disk byte offset
    localparam int LEN_W     = 32;   // request byte count
    localparam int CS_W      = 23;   // chunk size in sectors
    localparam int MC_W      = 5;    // member count register
    localparam int DISK_W    = 4;    // member disk index
    localparam int SECT_SH   = 9;    // 512-byte sectors
    localparam int PAGE_SH   = 12;   // 4096-byte pages
    localparam int DIV_W     = 40;   // (end position >> 9) needs 40 bits
    localparam int POS_W     = 50;   // internal disk position width
    localparam int MAX_MEMBERS = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SECTORS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_COUNT  = 1'd1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CFG = 1'b1;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Work descriptor handed from the front end to the back end
    typedef struct packed {
        logic              err;
        logic              lead;       // a single leading piece goes first
        logic [DISK_W-1:0] lead_disk;
        logic [OFF_W-1:0]  lead_off;
        logic [LEN_W-1:0]  lead_len;
        logic              stripe;     // striped span follows
        logic [DISK_W-1:0] ms;         // start disk of the span
        logic [DISK_W-1:0] me;         // end disk of the span
        logic [DISK_W-1:0] last_disk;  // last disk that gets a piece
        logic [LEN_W-1:0]  s;          // chunk bytes
        logic [LEN_W-1:0]  ws;         // start offset within chunk
        logic [LEN_W-1:0]  wep1;       // end offset within chunk, plus one
        logic [POS_W-1:0]  base_s;     // disk position of start chunk row
        logic [POS_W-1:0]  base_e;     // disk position of end chunk row
    } r0s_desc_t;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIV1 = 5'b00010,
        F_DIV2 = 5'b00100,
        F_MUL  = 5'b01000,
        F_PUSH = 5'b10000
    } r0s_fstate_t;

endpackage

`default_nettype wire

/* sv/r0s_if.sv */
// ----------------------------------------------------------------------------
// r0s_if
// Valid/ready channels of the RAID0 request splitter.
// ----------------------------------------------------------------------------
`default_nettype none

interface r0s_req_if
    import r0s_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [OFF_W-1:0] array_offset;
    logic [LEN_W-1:0] byte_length;

    modport source (output valid, kind, array_offset, byte_length, input ready);
    modport sink   (input valid, kind, array_offset, byte_length, output ready);
endinterface

interface r0s_piece_if
    import r0s_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              status;
    logic [DISK_W-1:0] disk;
    logic [OFF_W-1:0]  disk_offset;
    logic [LEN_W-1:0]  piece_length;
    logic              last;

    modport source (output valid, status, disk, disk_offset, piece_length, last,
                    input ready);
    modport sink   (input valid, status, disk, disk_offset, piece_length, last,
                    output ready);
endinterface

interface r0s_cfg_if
    import r0s_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CS_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/r0s_div.sv */
// ----------------------------------------------------------------------------
// r0s_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module r0s_div
    import r0s_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [CS_W-1:0]  divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient,
    output logic [CS_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [CS_W-1:0]  rem_reg;
    logic [CS_W:0]    trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? CS_W'(trial - {1'b0, divisor}) : trial[CS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* sv/r0s_front.sv */
// ----------------------------------------------------------------------------
// r0s_front
// Accepts requests, locates start/end chunks and builds a work descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module r0s_front
    import r0s_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    r0s_req_if.sink              req,
    input  wire logic [CS_W-1:0] chunk_sectors,
    input  wire logic [MC_W-1:0] member_count,
    output logic                 push,
    output r0s_desc_t            desc,
    input  wire logic            full
);

    r0s_fstate_t state_reg, state_next;

    logic             kind_reg;
    logic [OFF_W-1:0] off_reg;
    logic [LEN_W-1:0] len_reg;
    logic [SECT_SH-1:0] endlo_reg;
    logic             err_reg;
    logic [DIV_W-1:0] sc_reg, ec_reg, qs_reg, qe_reg;
    logic [CS_W-1:0]  rs_reg, re_reg;
    logic [DISK_W-1:0] ms_reg, me_reg;
    logic [POS_W-1:0] base_s_reg, base_e_reg;

    logic             accept;
    logic             bad_cfg;
    logic [MC_W-1:0]  n_eff;
    logic [DISK_W-1:0] nm1;
    logic [OFF_W:0]   endpos_in;
    logic             div_start;
    logic [DIV_W-1:0] dvd_a, dvd_b;
    logic [CS_W-1:0]  dvs;
    logic             done_a, done_b;
    logic [DIV_W-1:0] q_a, q_b;
    logic [CS_W-1:0]  r_a, r_b;
    logic [DIV_W+CS_W-1:0] prod_s, prod_e;

    assign accept  = req.valid && req.ready;
    assign bad_cfg = (chunk_sectors == '0) || (chunk_sectors[PAGE_SH-SECT_SH-1:0] != '0);
    assign n_eff   = (member_count == '0) ? MC_W'(1) :
                     (member_count > MC_W'(MAX_MEMBERS)) ? MC_W'(MAX_MEMBERS) : member_count;
    assign nm1     = DISK_W'(n_eff - 1'b1);

    assign endpos_in = (req.byte_length == '0) ? {1'b0, req.array_offset} :
                       {1'b0, req.array_offset} + (OFF_W+1)'(req.byte_length)
                       - (OFF_W+1)'(1);

    assign req.ready = (state_reg == F_IDLE);

    // first pass divides by chunk sectors, second by member count;
    // the divisor must stay put for the whole pass
    always_comb
    begin
        if (state_reg == F_IDLE)
        begin
            dvd_a     = DIV_W'(req.array_offset[OFF_W-1:SECT_SH]);
            dvd_b     = endpos_in[OFF_W:SECT_SH];
            dvs       = chunk_sectors;
            div_start = accept && !bad_cfg;
        end
        else
        begin
            dvd_a     = q_a;
            dvd_b     = q_b;
            dvs       = (state_reg == F_DIV1) ? chunk_sectors : CS_W'(n_eff);
            div_start = (state_reg == F_DIV1) && done_a;
        end
    end

    r0s_div u_div_a (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_a),
        .divisor(dvs), .done(done_a), .quotient(q_a), .remainder(r_a)
    );

    r0s_div u_div_b (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_b),
        .divisor(dvs), .done(done_b), .quotient(q_b), .remainder(r_b)
    );

    assign prod_s = qs_reg * chunk_sectors;
    assign prod_e = qe_reg * chunk_sectors;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (accept) state_next = bad_cfg ? F_PUSH : F_DIV1;
            F_DIV1: if (done_a) state_next = F_DIV2;
            F_DIV2: if (done_a && done_b) state_next = F_MUL;
            F_MUL:  state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req.kind;
            off_reg   <= req.array_offset;
            len_reg   <= req.byte_length;
            endlo_reg <= endpos_in[SECT_SH-1:0];
            err_reg   <= bad_cfg;
        end
        if (state_reg == F_DIV1 && done_a)
        begin
            sc_reg <= q_a;
            ec_reg <= q_b;
            rs_reg <= r_a;
            re_reg <= r_b;
        end
        if (state_reg == F_DIV2 && done_a)
        begin
            qs_reg <= q_a;
            qe_reg <= q_b;
            ms_reg <= r_a[DISK_W-1:0];
            me_reg <= r_b[DISK_W-1:0];
        end
        if (state_reg == F_MUL)
        begin
            base_s_reg <= {prod_s[POS_W-SECT_SH-1:0], {SECT_SH{1'b0}}};
            base_e_reg <= {prod_e[POS_W-SECT_SH-1:0], {SECT_SH{1'b0}}};
        end
    end

    // descriptor build
    logic [LEN_W-1:0]   s_bytes, chunk_pos, we;
    logic [POS_W-1:0]   soff;
    logic [PAGE_SH-1:0] pg_r;
    logic [PAGE_SH:0]   skip;
    logic               bump, wrap;
    logic [LEN_W:0]     wsum;
    logic [DIV_W-1:0]   sc2, cnt;
    logic [DISK_W-1:0]  ms2;

    assign s_bytes   = {chunk_sectors, {SECT_SH{1'b0}}};
    assign chunk_pos = {rs_reg, off_reg[SECT_SH-1:0]};
    assign we        = {re_reg, endlo_reg};
    assign soff      = base_s_reg + POS_W'(chunk_pos);
    assign pg_r      = off_reg[PAGE_SH-1:0];
    assign skip      = (pg_r == '0) ? '0 : (PAGE_SH+1)'(1 << PAGE_SH) - (PAGE_SH+1)'(pg_r);
    assign wsum      = (LEN_W+1)'(chunk_pos) + (LEN_W+1)'(skip);
    assign bump      = (wsum == (LEN_W+1)'(s_bytes));
    assign wrap      = bump && (ms_reg == nm1);

    always_comb
    begin
        desc           = '0;
        desc.s         = s_bytes;
        desc.me        = me_reg;
        desc.base_e    = base_e_reg;
        desc.wep1      = we + 1'b1;
        desc.lead_disk = ms_reg;
        desc.lead_off  = soff[OFF_W-1:0];
        desc.ms        = ms_reg;
        desc.base_s    = base_s_reg;
        sc2            = sc_reg;
        ms2            = ms_reg;
        if (err_reg)
        begin
            desc           = '0;
            desc.err       = 1'b1;
            desc.lead      = 1'b1;
        end
        else if (sc_reg == ec_reg)
        begin
            desc.lead     = 1'b1;
            desc.lead_len = len_reg;
        end
        else if (kind_reg == KIND_READ)
        begin
            desc.stripe = 1'b1;
            desc.ws     = chunk_pos - LEN_W'(pg_r);
        end
        else
        begin
            desc.lead     = (skip != '0);
            desc.lead_len = LEN_W'(skip);
            desc.stripe   = len_reg > LEN_W'(skip);
            if (bump)
            begin
                ms2         = wrap ? '0 : ms_reg + 1'b1;
                sc2         = sc_reg + 1'b1;
                desc.ws     = '0;
                desc.base_s = wrap ? base_s_reg + POS_W'(s_bytes) : base_s_reg;
            end
            else
            begin
                desc.ws = wsum[LEN_W-1:0];
            end
            desc.ms = ms2;
        end
        cnt = ec_reg - sc2;
        desc.last_disk = (cnt >= DIV_W'(nm1) || me_reg < ms2) ? nm1 : me_reg;
    end

    assign push = (state_reg == F_PUSH) && !full;

endmodule

`default_nettype wire

/* sv/r0s_fifo.sv */
// ----------------------------------------------------------------------------
// r0s_fifo
// Two-entry descriptor queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module r0s_fifo
    import r0s_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  r0s_desc_t      wdata,
    output logic           full,
    input  wire logic      pop,
    output r0s_desc_t      rdata,
    output logic           empty
);

    r0s_desc_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* sv/r0s_back.sv */
// ----------------------------------------------------------------------------
// r0s_back
// Walks a descriptor, one member disk per cycle while the output is not stalled, into output pieces.
// ----------------------------------------------------------------------------
`default_nettype none

module r0s_back
    import r0s_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  r0s_desc_t  desc,
    input  wire logic  empty,
    output logic       pop,
    r0s_piece_if.source piece
);

    r0s_desc_t         cur_reg;
    logic              have_reg, lead_pend_reg;
    logic [DISK_W-1:0] i_reg;
    logic              ov_reg, st_reg, last_reg;
    logic [DISK_W-1:0] disk_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [LEN_W-1:0]  len_reg;

    logic              slot_free;
    logic [POS_W-1:0]  a, b, diff;
    logic              emit;
    logic [LEN_W-1:0]  plen;

    assign slot_free = !ov_reg || piece.ready;
    assign pop       = !have_reg && !empty;

    always_comb
    begin
        if (i_reg < cur_reg.ms)
            a = cur_reg.base_s + POS_W'(cur_reg.s);
        else if (i_reg == cur_reg.ms)
            a = cur_reg.base_s + POS_W'(cur_reg.ws);
        else
            a = cur_reg.base_s;
        if (i_reg < cur_reg.me)
            b = cur_reg.base_e + POS_W'(cur_reg.s);
        else if (i_reg == cur_reg.me)
            b = cur_reg.base_e + POS_W'(cur_reg.wep1);
        else
            b = cur_reg.base_e;
    end

    assign emit = b > a;
    assign diff = b - a;
    assign plen = (diff[POS_W-1:LEN_W] != '0) ? '1 : diff[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            lead_pend_reg <= 1'b0;
            ov_reg        <= 1'b0;
            i_reg         <= '0;
        end
        else
        begin
            if (!have_reg)
            begin
                if (piece.ready)
                    ov_reg <= 1'b0;
                if (!empty)
                begin
                    have_reg      <= 1'b1;
                    lead_pend_reg <= desc.lead;
                    i_reg         <= '0;
                end
            end
            else if (slot_free)
            begin
                if (lead_pend_reg)
                begin
                    ov_reg        <= 1'b1;
                    lead_pend_reg <= 1'b0;
                    if (!cur_reg.stripe)
                        have_reg <= 1'b0;
                end
                else
                begin
                    ov_reg <= emit;
                    if (i_reg == cur_reg.last_disk)
                        have_reg <= 1'b0;
                    else
                        i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= desc;
        if (have_reg && slot_free)
        begin
            if (lead_pend_reg)
            begin
                st_reg   <= cur_reg.err ? STATUS_BAD_CFG : STATUS_OK;
                disk_reg <= cur_reg.lead_disk;
                off_reg  <= cur_reg.lead_off;
                len_reg  <= cur_reg.lead_len;
                last_reg <= !cur_reg.stripe;
            end
            else
            begin
                st_reg   <= STATUS_OK;
                disk_reg <= i_reg;
                off_reg  <= a[OFF_W-1:0];
                len_reg  <= plen;
                last_reg <= (i_reg == cur_reg.last_disk);
            end
        end
    end

    assign piece.valid        = ov_reg;
    assign piece.status       = st_reg;
    assign piece.disk         = disk_reg;
    assign piece.disk_offset  = off_reg;
    assign piece.piece_length = len_reg;
    assign piece.last         = last_reg;

endmodule

`default_nettype wire

/* sv/raid0_request_splitter.sv */
// ----------------------------------------------------------------------------
// raid0_request_splitter
// Splits one array access into per-member sub-requests of a RAID0 set.
// ----------------------------------------------------------------------------
// Channels: req (sink) takes one request: kind, array_offset, byte_length.
// piece (source) gives its sub-requests in order: a leading piece, if any,
// then disk 0 up; last marks the final one. cfg (sink, always ready) writes
// chunk_sectors (index 0) and member_count (index 1); write only when idle.
// Timing: the front end runs two passes of a pair of 40-step dividers
// (by chunk size, then by member count), a multiply state and a push state,
// and takes no new request until it has pushed the last one's descriptor.
// A bad chunk size skips the divides and yields one error piece.
// The back end loads a descriptor, then emits the leading piece, if any,
// then walks one disk per cycle, while the output is not stalled, up to
// the last disk of the descriptor.
// A two-entry queue lets the front end work on the next request while the
// back end is still emitting. A stalled receiver holds the output register,
// backs up the queue, and finally stops req.ready.
// Reset clears all control state and loads chunk_sectors 128, members 2.
// ----------------------------------------------------------------------------
`default_nettype none

module raid0_request_splitter
    import r0s_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    r0s_req_if.sink     req,
    r0s_piece_if.source piece,
    r0s_cfg_if.sink     cfg
);

    logic [CS_W-1:0] cs_reg;
    logic [MC_W-1:0] mc_reg;

    logic      push, full, pop, empty;
    r0s_desc_t wdesc, rdesc;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= CS_W'(128);
            mc_reg <= MC_W'(2);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CHUNK_SECTORS: cs_reg <= cfg.data;
                CFG_MEMBER_COUNT:  mc_reg <= cfg.data[MC_W-1:0];
                default: ;
            endcase
        end
    end

    // classify and locate chunks
    r0s_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .chunk_sectors(cs_reg), .member_count(mc_reg),
        .push(push), .desc(wdesc), .full(full)
    );

    r0s_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(wdesc), .full(full),
        .pop(pop), .rdata(rdesc), .empty(empty)
    );

    // emit pieces
    r0s_back u_back (
        .clk(clk), .rst_n(rst_n), .desc(rdesc), .empty(empty), .pop(pop),
        .piece(piece)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for raid0_request_splitter: directed and random
// requests under several chunk/member settings, checked piece by piece
// against a behavioral striping model, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import r0s_pkg::*;

    localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
    localparam longint unsigned PAGE   = 4096;

    typedef struct {
        bit              status;
        bit [DISK_W-1:0] disk;
        bit [OFF_W-1:0]  disk_offset;
        bit [LEN_W-1:0]  piece_length;
        bit              last;
    } piece_t;

    logic clk;
    logic rst_n;

    r0s_req_if   req();
    r0s_piece_if piece();
    r0s_cfg_if   cfg();

    raid0_request_splitter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .piece (piece),
        .cfg   (cfg)
    );

    // Shadow copies of the two registers, updated on each accepted write
    bit [CS_W-1:0] chunk_sectors_q;
    bit [MC_W-1:0] member_count_q;

    piece_t pending_pieces[$];     // expected sub-requests, oldest first
    int     error_count;
    int     requests_sent;
    int     pieces_checked;
    int     config_writes;
    int     send_idle_pct;
    int     recv_stall_pct;

    // ------------------------------------------------------------------------
    // Striping model
    // ------------------------------------------------------------------------
    function automatic void add_piece(ref piece_t pl[$], input bit st,
                                      input longint unsigned dk,
                                      input longint unsigned doff,
                                      input longint unsigned ln);
        piece_t p;
        p.status       = st;
        p.disk         = dk[DISK_W-1:0];
        p.disk_offset  = doff[OFF_W-1:0];
        p.piece_length = (ln > MASK32) ? 32'hFFFF_FFFF : ln[LEN_W-1:0];
        p.last         = 1'b0;
        pl.push_back(p);
    endfunction

    // One contiguous piece per touched disk, disk 0 upward
    function automatic void stripe_span(ref piece_t pl[$],
                                        input longint unsigned off,
                                        input longint unsigned len,
                                        input longint unsigned s,
                                        input longint unsigned n);
        longint unsigned e, sd, so, ed, eo, a, b;
        e  = off + len - 1;
        sd = (off / s) % n;
        so = (off / (s * n)) * s + off % s;
        ed = (e / s) % n;
        eo = (e / (s * n)) * s + e % s;
        for (longint unsigned i = 0; i < n; i++)
        begin
            if (sd > i)
                a = so - so % s + s;
            else if (sd == i)
                a = so;
            else
                a = so - so % s;
            if (ed > i)
                b = eo - eo % s + s;
            else if (ed == i)
                b = eo + 1;
            else
                b = eo - eo % s;
            if (b > a)
                add_piece(pl, STATUS_OK, i, a, b - a);
        end
    endfunction

    function automatic void split_request(bit kind, bit [OFF_W-1:0] aoff,
                                          bit [LEN_W-1:0] blen);
        piece_t pl[$];
        longint unsigned s, n, off, len, endpos, sc, ec, skip, r;
        s   = longint'(chunk_sectors_q) * 512;
        n   = member_count_q;
        off = aoff;
        len = blen;
        if (chunk_sectors_q == 0 || s % PAGE != 0)
        begin
            add_piece(pl, STATUS_BAD_CFG, 0, 0, 0);
        end
        else
        begin
            if (n == 0)
                n = 1;
            if (n > MAX_MEMBERS)
                n = MAX_MEMBERS;
            endpos = (len == 0) ? off : off + len - 1;
            sc = off / s;
            ec = endpos / s;
            if (sc == ec)
                add_piece(pl, STATUS_OK, sc % n, (sc / n) * s + off % s, len);
            else if (kind == KIND_READ)
            begin
                // read: pull the start down to a page boundary
                skip = off % PAGE;
                stripe_span(pl, off - skip, len + skip, s, n);
            end
            else
            begin
                // write: unaligned head page goes out alone
                r = off % PAGE;
                skip = (r != 0) ? PAGE - r : 0;
                if (skip != 0)
                begin
                    add_piece(pl, STATUS_OK, sc % n, (sc / n) * s + off % s, skip);
                    off += skip;
                    len = (len > skip) ? len - skip : 0;
                end
                if (len > 0)
                    stripe_span(pl, off, len, s, n);
            end
            if (pl.size() == 0)
                add_piece(pl, STATUS_OK, 0, 0, 0);
        end
        pl[pl.size()-1].last = 1'b1;
        foreach (pl[i])
            pending_pieces.push_back(pl[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Piece receiver: check at the edge, then pick next ready
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        piece_t exp_p;
        if (rst_n && piece.valid && piece.ready)
        begin
            if (pending_pieces.size() == 0)
            begin
                $error("unexpected piece: disk %0d offset %0h", piece.disk,
                       piece.disk_offset);
                error_count++;
            end
            else
            begin
                exp_p = pending_pieces.pop_front();
                pieces_checked++;
                if (piece.status !== exp_p.status)
                begin
                    $error("status: expected %0d, got %0d", exp_p.status, piece.status);
                    error_count++;
                end
                if (piece.disk !== exp_p.disk)
                begin
                    $error("disk: expected %0d, got %0d", exp_p.disk, piece.disk);
                    error_count++;
                end
                if (piece.disk_offset !== exp_p.disk_offset)
                begin
                    $error("disk_offset: expected %0h, got %0h", exp_p.disk_offset,
                           piece.disk_offset);
                    error_count++;
                end
                if (piece.piece_length !== exp_p.piece_length)
                begin
                    $error("piece_length: expected %0h, got %0h", exp_p.piece_length,
                           piece.piece_length);
                    error_count++;
                end
                if (piece.last !== exp_p.last)
                begin
                    $error("last: expected %0d, got %0d", exp_p.last, piece.last);
                    error_count++;
                end
            end
        end
        piece.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers (called right after a rising edge)
    // ------------------------------------------------------------------------
    task automatic send_request(bit kind, bit [OFF_W-1:0] aoff, bit [LEN_W-1:0] blen);
        if (int'($urandom_range(99)) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.kind         <= kind;
        req.array_offset <= aoff;
        req.byte_length  <= blen;
        do
            @(posedge clk);
        while (!(req.valid && req.ready));
        split_request(kind, aoff, blen);
        requests_sent++;
    endtask

    // Let every expected piece arrive, plus slack for the pipeline
    task automatic drain;
        req.valid <= 1'b0;
        while (pending_pieces.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CS_W-1:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!(cfg.valid && cfg.ready));
        cfg.valid <= 1'b0;
        if (idx == CFG_CHUNK_SECTORS)
            chunk_sectors_q = value;
        else
            member_count_q = value[MC_W-1:0];
        config_writes++;
    endtask

    task automatic set_layout(bit [CS_W-1:0] cs, bit [MC_W-1:0] mc);
        write_reg(CFG_CHUNK_SECTORS, cs);
        write_reg(CFG_MEMBER_COUNT, {{(CS_W-MC_W){1'b0}}, mc});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset layout: 64 KiB chunks, 2 members
    task automatic test_reset_layout;
        send_request(KIND_READ,  48'h0,              32'd1);
        send_request(KIND_READ,  48'h1_0000,         32'd0);        // zero length
        send_request(KIND_READ,  48'h0_F123,         32'h2_0000);   // spans, unaligned
        send_request(KIND_WRITE, 48'h0_F123,         32'h2_0000);   // head page first
        send_request(KIND_WRITE, 48'h0_F123,         32'd3900);     // head page, then a short rest
        send_request(KIND_WRITE, 48'h2_0000,         32'h3_0000);   // aligned span
        send_request(KIND_READ,  48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_WRITE, 48'hFFFF_FFFF_F001, 32'hFFFF_FFFF);
    endtask

    // Smallest and largest good chunks, member clamping, saturated pieces
    task automatic test_layout_limits;
        set_layout(23'd8, 5'd16);
        send_request(KIND_READ,  48'h123,            32'hFFFF_FFFF);
        send_request(KIND_WRITE, 48'h0_0FFF,         32'h1_2345);
        set_layout(23'd8388600, 5'd1);
        send_request(KIND_READ,  48'h1FF_FFFF_0FFF,  32'hFFFF_FFFF); // saturates
        send_request(KIND_WRITE, 48'h0,              32'hFFFF_FFFF);
        set_layout(23'd16, 5'd0);                                    // acts as 1
        send_request(KIND_READ,  48'h1_ABCD,         32'h3_0000);
        set_layout(23'd24, 5'd31);                                   // acts as 16
        send_request(KIND_READ,  48'h7_1234,         32'h20_0000);
        send_request(KIND_WRITE, 48'h7_1234,         32'h20_0000);
        set_layout(23'd8, 5'd17);
        send_request(KIND_WRITE, 48'hABC_DEF0_1357,  32'h4_5678);
    endtask

    // Zero or non-page chunk sizes give the single error piece
    task automatic test_bad_chunk;
        set_layout(23'd0, 5'd4);
        send_request(KIND_READ,  48'h1000,           32'd4096);
        set_layout(23'd8388607, 5'd4);
        send_request(KIND_WRITE, 48'h1234,           32'h10_0000);
        set_layout(23'd12, 5'd4);
        send_request(KIND_READ,  48'h0,              32'd1);
    endtask

    task automatic random_request;
        bit [OFF_W-1:0]  aoff;
        bit [LEN_W-1:0]  blen;
        longint unsigned span;
        aoff = OFF_W'({$urandom, $urandom});
        if ($urandom_range(3) == 0)
            aoff[11:0] = 12'h0;          // page-aligned start
        span = longint'(chunk_sectors_q) * 512 * 2 * (member_count_q + 1);
        if (span > MASK32 || span == 0)
            span = MASK32;
        case ($urandom_range(7))
            0:       blen = $urandom;
            1:       blen = $urandom_range(0, 8192);
            default: blen = $urandom_range(1, span[31:0]);
        endcase
        send_request(1'($urandom), aoff, blen);
    endtask

    // Random layouts, 40 requests each, under the four idling modes
    task automatic test_random;
        bit [CS_W-1:0] cs;
        for (int mode = 0; mode < 4; mode++)
        begin
            drain();
            send_idle_pct  = (mode == 1) ? 81 : (mode == 3) ? 8 : 0;
            recv_stall_pct = (mode == 2) ? 81 : (mode == 3) ? 8 : 0;
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(9))
                    0:       cs = CS_W'($urandom);                 // often bad
                    1:       cs = 23'($urandom_range(1, 1048575)) << 3;
                    default: cs = 23'($urandom_range(1, 16)) << 3; // small chunks
                endcase
                set_layout(cs, 5'($urandom));
                repeat (40) random_request();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.kind         = KIND_READ;
        req.array_offset = '0;
        req.byte_length  = '0;
        cfg.valid        = 1'b0;
        cfg.index        = CFG_CHUNK_SECTORS;
        cfg.data         = '0;
        chunk_sectors_q  = 23'd128;
        member_count_q   = 5'd2;
        error_count      = 0;
        requests_sent    = 0;
        pieces_checked   = 0;
        config_writes    = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_layout_limits();
        test_bad_chunk();
        test_random();
        drain();

        $display("Covered %0d requests, %0d pieces checked, %0d register writes",
                 requests_sent, pieces_checked, config_writes);
        $display("over small/maximal/bad chunk sizes and clamped member counts.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
